>>> hw/rtl/limit_order_matcher_assert.svh
// Assertion macros for the order matcher.
`ifndef LIMIT_ORDER_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_ASSERT_SVH
`ifndef SYNTH
`define LOM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define LOM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define LOM_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define LOM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> hw/rtl/lom_pkg.sv
package lom_pkg;
    localparam int ORDERS_PER_SIDE = 32;
    localparam int PRICE_BITS = 16;
    localparam int CNT_BITS = $clog2(ORDERS_PER_SIDE + 1);

    typedef struct packed {
        logic [31:0]           id;
        logic [PRICE_BITS-1:0] price;
        logic [15:0]           qty;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_POP,
        OP_DEC,
        OP_INSERT
    } op_t;

    // command broadcast to every cell of one side
    typedef struct packed {
        op_t                   op;
        logic [15:0]           dec;
        entry_t                ins;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DONE
    } state_t;

    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;
endpackage

>>> hw/rtl/lom_cell.sv
module lom_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            bid_side,
    input  lom_pkg::cmd_t   cmd,
    input  lom_pkg::entry_t prev_entry,
    input  logic            prev_valid,
    input  lom_pkg::entry_t next_entry,
    input  logic            next_valid,
    input  logic            prev_after,
    output lom_pkg::entry_t entry,
    output logic            valid,
    output logic            after
);
    lom_pkg::entry_t entry_reg;
    lom_pkg::entry_t entry_next;
    logic            valid_reg;
    logic            valid_next;

    // new entry goes after this one
    assign after = valid_reg &&
        (bid_side ? (entry_reg.price >= cmd.ins.price) : (entry_reg.price <= cmd.ins.price));

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (cmd.op)
            lom_pkg::OP_POP:
            begin
                entry_next = next_entry;
                valid_next = next_valid;
            end
            lom_pkg::OP_DEC:
            begin
                if (!prev_valid)
                begin
                    entry_next.qty = entry_reg.qty - cmd.dec;
                end
            end
            lom_pkg::OP_INSERT:
            begin
                if (prev_after && !after)
                begin
                    entry_next = cmd.ins;
                    valid_next = 1'b1;
                end
                else if (!after)
                begin
                    entry_next = prev_entry;
                    valid_next = prev_valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
endmodule

>>> hw/rtl/lom_side.sv
module lom_side (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            bid_side,
    input  lom_pkg::cmd_t   cmd,
    output lom_pkg::entry_t head,
    output logic            head_valid,
    output logic            full
);
    localparam int N = lom_pkg::ORDERS_PER_SIDE;

    lom_pkg::entry_t e [N];
    logic            v [N];
    logic            a [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            lom_pkg::entry_t pe;
            lom_pkg::entry_t ne;
            logic            pv;
            logic            nv;
            logic            pa;
            if (i == 0)
            begin : g_first
                assign pe = e[0];
                assign pv = 1'b0;
                assign pa = 1'b1;
            end
            else
            begin : g_mid
                assign pe = e[i-1];
                assign pv = v[i-1];
                assign pa = a[i-1];
            end
            if (i == N - 1)
            begin : g_last
                assign ne = e[i];
                assign nv = 1'b0;
            end
            else
            begin : g_nxt
                assign ne = e[i+1];
                assign nv = v[i+1];
            end
            lom_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .bid_side   (bid_side),
                .cmd        (cmd),
                .prev_entry (pe),
                .prev_valid (pv),
                .next_entry (ne),
                .next_valid (nv),
                .prev_after (pa),
                .entry      (e[i]),
                .valid      (v[i]),
                .after      (a[i])
            );
        end
    endgenerate

    assign head       = e[0];
    assign head_valid = v[0];
    assign full       = v[N-1];
endmodule

>>> hw/rtl/limit_order_matcher.sv
// limit_order_matcher: price-time priority limit order book.
// Input channel (valid/ready): order_id, side (0 buy, 1 sell), limit_price,
// order_qty. Output channel (valid/ready): kind, buy_id, sell_id,
// trade_price, fill_qty, overflow, last.
// Each side is a row of cells sorted best price first; the head cell is
// the only one matched against. A fill that empties the head cell shifts
// the whole row forward, a partial fill lowers the head's quantity, and an
// insert shifts the cells behind its place back. One order is handled at a
// time: each trade is emitted from the match state until the book no longer
// crosses or the order is filled, then the done item is emitted; the
// remainder inserts in the cycle that the done item is taken, or sets
// overflow if its side is full. The block is ready for the next request in
// the cycle after the done item is taken. The done item has last set.
// Reset empties both sides and the block then takes orders at once.
// A stall on the output holds the current result and the book; no input is
// taken until the done item of the current order is taken.
`include "limit_order_matcher_assert.svh"
module limit_order_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] order_id,
    input  logic        side,
    input  logic [15:0] limit_price,
    input  logic [15:0] order_qty,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [31:0] buy_id,
    output logic [31:0] sell_id,
    output logic [15:0] trade_price,
    output logic [15:0] fill_qty,
    output logic        overflow,
    output logic        last
);
    localparam int PB = lom_pkg::PRICE_BITS;

    lom_pkg::state_t state_reg;
    lom_pkg::state_t state_next;

    logic [31:0]   id_reg;
    logic          sell_reg;
    logic [PB-1:0] lim_reg;
    logic [15:0]   rem_reg;
    logic [15:0]   rem_next;

    lom_pkg::cmd_t   bid_cmd;
    lom_pkg::cmd_t   ask_cmd;
    lom_pkg::entry_t bid_head;
    lom_pkg::entry_t ask_head;
    logic            bid_hv;
    logic            ask_hv;
    logic            bid_full;
    logic            ask_full;

    lom_pkg::entry_t opp_head;
    logic            opp_hv;
    logic            own_full;
    logic            crossing;
    logic            match_now;
    logic [15:0]     fill;
    lom_pkg::entry_t ins;
    lom_pkg::cmd_t   opp_cmd;
    lom_pkg::cmd_t   own_cmd;
    logic            fire;

    assign opp_head = sell_reg ? bid_head : ask_head;
    assign opp_hv   = sell_reg ? bid_hv : ask_hv;
    assign own_full = sell_reg ? ask_full : bid_full;
    assign crossing = sell_reg ? (opp_head.price >= lim_reg) : (opp_head.price <= lim_reg);
    assign match_now = (rem_reg != 16'd0) && opp_hv && crossing;
    assign fill     = (rem_reg < opp_head.qty) ? rem_reg : opp_head.qty;
    assign fire     = out_valid && out_ready;

    assign ins.id    = id_reg;
    assign ins.price = lim_reg;
    assign ins.qty   = rem_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lom_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lom_pkg::ST_MATCH;
                end
            end
            lom_pkg::ST_MATCH:
            begin
                if (!match_now)
                begin
                    state_next = lom_pkg::ST_DONE;
                end
            end
            lom_pkg::ST_DONE:
            begin
                if (fire)
                begin
                    state_next = lom_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lom_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        kind      = lom_pkg::KIND_TRADE;
        buy_id    = sell_reg ? opp_head.id : id_reg;
        sell_id   = sell_reg ? id_reg : opp_head.id;
        trade_price = 16'(opp_head.price);
        fill_qty  = fill;
        overflow  = 1'b0;
        last      = 1'b0;
        rem_next  = rem_reg;
        opp_cmd   = '{op: lom_pkg::OP_HOLD, dec: fill, ins: ins};
        own_cmd   = '{op: lom_pkg::OP_HOLD, dec: fill, ins: ins};
        case (state_reg)
            lom_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            lom_pkg::ST_MATCH:
            begin
                out_valid = match_now;
                if (match_now && out_ready)
                begin
                    rem_next = rem_reg - fill;
                    opp_cmd.op = (fill == opp_head.qty) ? lom_pkg::OP_POP : lom_pkg::OP_DEC;
                end
            end
            lom_pkg::ST_DONE:
            begin
                out_valid   = 1'b1;
                kind        = lom_pkg::KIND_DONE;
                buy_id      = sell_reg ? 32'd0 : id_reg;
                sell_id     = sell_reg ? id_reg : 32'd0;
                trade_price = 16'(lim_reg);
                fill_qty    = (rem_reg != 16'd0 && !own_full) ? rem_reg : 16'd0;
                overflow    = (rem_reg != 16'd0) && own_full;
                last        = 1'b1;
                if (out_ready && rem_reg != 16'd0 && !own_full)
                begin
                    own_cmd.op = lom_pkg::OP_INSERT;
                end
            end
            default:
            begin
            end
        endcase
        bid_cmd = sell_reg ? opp_cmd : own_cmd;
        ask_cmd = sell_reg ? own_cmd : opp_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lom_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            id_reg   <= order_id;
            sell_reg <= side;
            lim_reg  <= limit_price[PB-1:0];
            rem_reg  <= order_qty;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    lom_side u_bids (
        .clk        (clk),
        .rst_n      (rst_n),
        .bid_side   (1'b1),
        .cmd        (bid_cmd),
        .head       (bid_head),
        .head_valid (bid_hv),
        .full       (bid_full)
    );

    lom_side u_asks (
        .clk        (clk),
        .rst_n      (rst_n),
        .bid_side   (1'b0),
        .cmd        (ask_cmd),
        .head       (ask_head),
        .head_valid (ask_hv),
        .full       (ask_full)
    );

    `LOM_ASSERT_IMPLY(a_ready_idle, clk, rst_n, in_ready, !out_valid)
    `LOM_ASSERT_IMPLY(a_last_done, clk, rst_n, out_valid && last, kind == lom_pkg::KIND_DONE)
    `LOM_ASSERT_IMPLY(a_trade_nz, clk, rst_n, out_valid && !last, fill_qty != 16'd0)
    `LOM_ASSERT_NEXT(a_done_idle, clk, rst_n, fire && last, in_ready)
endmodule
